[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Clock is i_clk, reset i_rst_n (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[hw/rtl/gbk_tl_pkg.sv]
package gbk_tl_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_AREA_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_AREA_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_LARGE_FONT  = 3'd2;
    localparam logic [2:0] CFG_GBK16_BASE  = 3'd3;
    localparam logic [2:0] CFG_GB24_BASE   = 3'd4;

    // Reset values of the configuration registers
    localparam logic [15:0] AREA_WIDTH_RST  = 16'd320;
    localparam logic [15:0] AREA_HEIGHT_RST = 16'd240;

    // Draw command kinds
    typedef enum logic [2:0] {
        EV_DRAW_CHAR   = 3'd0,
        EV_DRAW_GLYPH  = 3'd1,
        EV_BLANK_GLYPH = 3'd2,
        EV_STRING_END  = 3'd3,
        EV_AREA_FULL   = 3'd4
    } t_event;

    // Special text bytes
    localparam logic [7:0] BYTE_END       = 8'h00;
    localparam logic [7:0] BYTE_CR        = 8'd13;
    localparam logic [7:0] LEAD_THRESHOLD = 8'h80;

    // GBK 16 pixel table ranges
    localparam logic [7:0] GBK_LEAD_MIN   = 8'h81;
    localparam logic [7:0] GBK_TRAIL_MIN  = 8'h40;
    localparam logic [7:0] GBK_TRAIL_GAP  = 8'h7f;
    localparam logic [7:0] GBK_TRAIL_SKIP = 8'h41;
    localparam logic [7:0] GBK_INVALID    = 8'hff;
    localparam logic [7:0] GBK_ROW_LEN    = 8'd190;

    // GB2312 24 pixel table ranges
    localparam logic [7:0] GB_OFFSET  = 8'ha1;
    localparam logic [6:0] GB_ROW_LEN = 7'd94;

    // Font geometry
    localparam logic [15:0] SIZE_SMALL  = 16'd16;
    localparam logic [15:0] SIZE_LARGE  = 16'd24;
    localparam logic [6:0]  BYTES_SMALL = 7'd32;
    localparam logic [6:0]  BYTES_LARGE = 7'd72;

    // True when the lead/trail pair has no 16 pixel glyph
    function automatic logic gbk16_invalid(input logic [7:0] lead, input logic [7:0] trail);
        gbk16_invalid = (lead < GBK_LEAD_MIN) || (trail < GBK_TRAIL_MIN) ||
                        (trail == GBK_INVALID) || (lead == GBK_INVALID);
    endfunction

    // Flash address of a 16 pixel GBK glyph, 32 bytes each
    function automatic logic [24:0] gbk16_addr(input logic [23:0] base,
                                               input logic [7:0] lead,
                                               input logic [7:0] trail);
        logic [7:0]  col;
        logic [7:0]  row;
        logic [15:0] idx;
        col = (trail < GBK_TRAIL_GAP) ? (trail - GBK_TRAIL_MIN) : (trail - GBK_TRAIL_SKIP);
        row = lead - GBK_LEAD_MIN;
        idx = 16'(row) * 16'(GBK_ROW_LEN) + {8'h00, col};
        gbk16_addr = {1'b0, base} + {4'h0, idx[15:0], 5'b00000};
    endfunction

    // Flash address of a 24 pixel GB2312 glyph, 72 bytes each
    function automatic logic [24:0] gb24_addr(input logic [23:0] base,
                                              input logic [7:0] lead,
                                              input logic [7:0] trail);
        logic [7:0]  row;
        logic [7:0]  col;
        logic [14:0] idx;
        logic [21:0] offs;
        row  = lead - GB_OFFSET;
        col  = trail - GB_OFFSET;
        idx  = 15'(row) * 15'(GB_ROW_LEN) + {7'h00, col};
        // times 72 as times 64 plus times 8
        offs = {1'b0, idx, 6'b000000} + {4'h0, idx, 3'b000};
        gb24_addr = {1'b0, base} + {3'b000, offs};
    endfunction

endpackage

[hw/rtl/gbk_text_layout_glyph_address.sv]
// Registers: input register, then output register driving m_axis.
// Throughput: one text byte per cycle while m_axis is not back-pressured; the pen update is
// one pass of compares and adds between the input register and the output register.
// Lead bytes, line breaks and bytes while stopped give no draw command.
// Reset (synchronous, active low): pen and line state cleared, block stopped until a
// string starts, configuration back to 320 x 240, 16 pixel font, table bases 0.
`include "assert_macros.svh"

module gbk_text_layout_glyph_address (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    // text bytes in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // start_x[15:0], start_y[31:16], text_byte[39:32]
    input  logic [0:0]  s_axis_tuser,  // start_of_string[0]
    // draw commands out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // pos_x[15:0], pos_y[31:16], char_code[39:32],
                                       // glyph_addr[64:40], glyph_bytes[71:65]
    output logic [2:0]  m_axis_tuser   // event_res[2:0]
);

    // Configuration registers
    logic [15:0] r_area_width;
    logic [15:0] r_area_height;
    logic        r_large_font;
    logic [23:0] r_gbk16_base;
    logic [23:0] r_gb24_base;

    // Layout state
    logic [15:0] r_pen_x;
    logic [15:0] r_pen_y;
    logic [15:0] r_line_left;
    logic [15:0] r_area_top;
    logic [7:0]  r_held_lead;
    logic        r_lead_pending;
    logic        r_halted;

    // Input register
    logic        r_in_valid;
    logic        r_in_sos;
    logic [15:0] r_in_start_x;
    logic [15:0] r_in_start_y;
    logic [7:0]  r_in_byte;

    // Output register
    logic                 r_out_valid;
    gbk_tl_pkg::t_event   r_out_event;
    logic [15:0]          r_out_pos_x;
    logic [15:0]          r_out_pos_y;
    logic [7:0]           r_out_char;
    logic [24:0]          r_out_addr;
    logic [6:0]           r_out_bytes;

    // Next state and result of the item in the input register
    logic [15:0]          n_pen_x;
    logic [15:0]          n_pen_y;
    logic [15:0]          n_line_left;
    logic [15:0]          n_area_top;
    logic [7:0]           n_held_lead;
    logic                 n_lead_pending;
    logic                 n_halted;
    logic                 w_has_res;
    gbk_tl_pkg::t_event   w_event;
    logic [15:0]          w_pos_x;
    logic [15:0]          w_pos_y;
    logic [7:0]           w_char;
    logic [24:0]          w_addr;
    logic [6:0]           w_bytes;

    // Layout helpers
    logic [15:0] w_size;
    logic [15:0] w_item_w;
    logic [15:0] w_eff_x;
    logic [15:0] w_eff_y;
    logic [15:0] w_eff_left;
    logic [15:0] w_eff_top;
    logic        w_eff_pending;
    logic        w_eff_halted;
    logic        w_wrap;
    logic [15:0] w_wrap_x;
    logic [15:0] w_wrap_y;
    logic        w_full;
    logic [24:0] w_addr16;
    logic [24:0] w_addr24;
    logic        w_blank16;

    logic        w_advance;
    logic        w_in_fire;

    assign o_cfg_ready = 1'b1;

    // Input stage moves when its item needs no output slot or the slot frees up
    assign w_advance     = r_in_valid && (!w_has_res || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    // Font geometry
    assign w_size = r_large_font ? gbk_tl_pkg::SIZE_LARGE : gbk_tl_pkg::SIZE_SMALL;

    // State seen by this byte: a string start loads the pen first
    assign w_eff_x       = r_in_sos ? r_in_start_x : r_pen_x;
    assign w_eff_y       = r_in_sos ? r_in_start_y : r_pen_y;
    assign w_eff_left    = r_in_sos ? r_in_start_x : r_line_left;
    assign w_eff_top     = r_in_sos ? r_in_start_y : r_area_top;
    assign w_eff_pending = r_in_sos ? 1'b0 : r_lead_pending;
    assign w_eff_halted  = r_in_sos ? 1'b0 : r_halted;

    // Wrap and area check; x > left + width - w rewritten as x + w > left + width
    assign w_item_w = w_eff_pending ? w_size : {1'b0, w_size[15:1]};
    assign w_wrap   = ({2'b00, w_eff_x} + {2'b00, w_item_w}) >
                      ({2'b00, w_eff_left} + {2'b00, r_area_width});
    assign w_wrap_x = w_wrap ? w_eff_left : w_eff_x;
    assign w_wrap_y = w_wrap ? (w_eff_y + w_size) : w_eff_y;
    assign w_full   = ({2'b00, w_wrap_y} + {2'b00, w_size}) >
                      ({2'b00, w_eff_top} + {2'b00, r_area_height});

    // Glyph addresses
    assign w_blank16 = gbk_tl_pkg::gbk16_invalid(r_held_lead, r_in_byte);
    assign w_addr16  = gbk_tl_pkg::gbk16_addr(r_gbk16_base, r_held_lead, r_in_byte);
    assign w_addr24  = gbk_tl_pkg::gb24_addr(r_gb24_base, r_held_lead, r_in_byte);

    // Per-byte layout decision
    always_comb begin
        n_pen_x        = w_eff_x;
        n_pen_y        = w_eff_y;
        n_line_left    = w_eff_left;
        n_area_top     = w_eff_top;
        n_held_lead    = r_held_lead;
        n_lead_pending = w_eff_pending;
        n_halted       = w_eff_halted;
        w_has_res      = 1'b0;
        w_event        = gbk_tl_pkg::EV_STRING_END;
        w_pos_x        = w_eff_x;
        w_pos_y        = w_eff_y;
        w_char         = 8'h00;
        w_addr         = 25'd0;
        w_bytes        = 7'd0;
        if (!w_eff_halted) begin
            if (!w_eff_pending && r_in_byte > gbk_tl_pkg::LEAD_THRESHOLD) begin
                // lead byte: hold it
                n_held_lead    = r_in_byte;
                n_lead_pending = 1'b1;
            end else if (r_in_byte == gbk_tl_pkg::BYTE_END) begin
                // end of string, any held lead dropped
                n_lead_pending = 1'b0;
                n_halted       = 1'b1;
                w_has_res      = 1'b1;
                w_event        = gbk_tl_pkg::EV_STRING_END;
            end else begin
                n_lead_pending = 1'b0;
                n_pen_x        = w_wrap_x;
                n_pen_y        = w_wrap_y;
                w_pos_x        = w_wrap_x;
                w_pos_y        = w_wrap_y;
                if (w_full) begin
                    n_halted  = 1'b1;
                    w_has_res = 1'b1;
                    w_event   = gbk_tl_pkg::EV_AREA_FULL;
                end else if (w_eff_pending) begin
                    // trail byte: one glyph
                    w_has_res = 1'b1;
                    n_pen_x   = w_wrap_x + w_size;
                    if (r_large_font) begin
                        w_event = gbk_tl_pkg::EV_DRAW_GLYPH;
                        w_addr  = w_addr24;
                        w_bytes = gbk_tl_pkg::BYTES_LARGE;
                    end else if (w_blank16) begin
                        w_event = gbk_tl_pkg::EV_BLANK_GLYPH;
                        w_bytes = gbk_tl_pkg::BYTES_SMALL;
                    end else begin
                        w_event = gbk_tl_pkg::EV_DRAW_GLYPH;
                        w_addr  = w_addr16;
                        w_bytes = gbk_tl_pkg::BYTES_SMALL;
                    end
                end else if (r_in_byte == gbk_tl_pkg::BYTE_CR) begin
                    // line break, no draw command
                    n_pen_x = w_eff_left;
                    n_pen_y = w_wrap_y + w_size;
                end else begin
                    w_has_res = 1'b1;
                    w_event   = gbk_tl_pkg::EV_DRAW_CHAR;
                    w_char    = r_in_byte;
                    n_pen_x   = w_wrap_x + {1'b0, w_size[15:1]};
                end
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_width  <= gbk_tl_pkg::AREA_WIDTH_RST;
            r_area_height <= gbk_tl_pkg::AREA_HEIGHT_RST;
            r_large_font  <= 1'b0;
            r_gbk16_base  <= 24'd0;
            r_gb24_base   <= 24'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gbk_tl_pkg::CFG_AREA_WIDTH:  r_area_width  <= i_cfg_data[15:0];
                gbk_tl_pkg::CFG_AREA_HEIGHT: r_area_height <= i_cfg_data[15:0];
                gbk_tl_pkg::CFG_LARGE_FONT:  r_large_font  <= i_cfg_data[0];
                gbk_tl_pkg::CFG_GBK16_BASE:  r_gbk16_base  <= i_cfg_data;
                gbk_tl_pkg::CFG_GB24_BASE:   r_gb24_base   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Layout state, updated as the item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x        <= 16'd0;
            r_pen_y        <= 16'd0;
            r_line_left    <= 16'd0;
            r_area_top     <= 16'd0;
            r_held_lead    <= 8'd0;
            r_lead_pending <= 1'b0;
            r_halted       <= 1'b1;
        end else if (w_advance) begin
            r_pen_x        <= n_pen_x;
            r_pen_y        <= n_pen_y;
            r_line_left    <= n_line_left;
            r_area_top     <= n_area_top;
            r_held_lead    <= n_held_lead;
            r_lead_pending <= n_lead_pending;
            r_halted       <= n_halted;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_sos     <= s_axis_tuser[0];
            r_in_start_x <= s_axis_tdata[15:0];
            r_in_start_y <= s_axis_tdata[31:16];
            r_in_byte    <= s_axis_tdata[39:32];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_has_res) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_has_res) begin
            r_out_event <= w_event;
            r_out_pos_x <= w_pos_x;
            r_out_pos_y <= w_pos_y;
            r_out_char  <= w_char;
            r_out_addr  <= w_addr;
            r_out_bytes <= w_bytes;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_event;
    assign m_axis_tdata  = {r_out_bytes, r_out_addr, r_out_char, r_out_pos_y, r_out_pos_x};

    // Checks
    `ASSERT_IMPL(a_bytes_match_event, r_out_valid,
        ((r_out_bytes != 7'd0) == (r_out_event == gbk_tl_pkg::EV_DRAW_GLYPH ||
                                   r_out_event == gbk_tl_pkg::EV_BLANK_GLYPH)),
        "glyph byte count does not match event kind")
    `ASSERT_NEXT(a_stop_after_end, w_advance && w_has_res &&
        (w_event == gbk_tl_pkg::EV_STRING_END || w_event == gbk_tl_pkg::EV_AREA_FULL),
        r_halted && !r_lead_pending, "block not stopped after end or full")
    `ASSERT_NEXT(a_in_reg_held, r_in_valid && !w_advance,
        r_in_valid && $stable(r_in_byte) && $stable(r_in_sos),
        "input register lost or changed a waiting transaction")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    // One draw command as seen on the output stream
    typedef struct packed {
        gbk_tl_pkg::t_event ev;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  code;
        logic [24:0] addr;
        logic [6:0]  nbytes;
    } t_draw_cmd;

    // Layout predictor plus the queue of draw commands it has produced
    class draw_scoreboard;
        logic [15:0] area_w;
        logic [15:0] area_h;
        bit          big_font;
        logic [23:0] base16;
        logic [23:0] base24;
        logic [15:0] pen_x;
        logic [15:0] pen_y;
        logic [15:0] line_left;
        logic [15:0] area_top;
        logic [7:0]  held_lead;
        bit          lead_pending;
        bit          halted;
        t_draw_cmd   expected_draws[$];
        int          errors;

        function new();
            area_w       = gbk_tl_pkg::AREA_WIDTH_RST;
            area_h       = gbk_tl_pkg::AREA_HEIGHT_RST;
            big_font     = 1'b0;
            base16       = '0;
            base24       = '0;
            pen_x        = '0;
            pen_y        = '0;
            line_left    = '0;
            area_top     = '0;
            held_lead    = '0;
            lead_pending = 1'b0;
            halted       = 1'b1;
            errors       = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [23:0] val);
            case (idx)
                gbk_tl_pkg::CFG_AREA_WIDTH:  area_w   = val[15:0];
                gbk_tl_pkg::CFG_AREA_HEIGHT: area_h   = val[15:0];
                gbk_tl_pkg::CFG_LARGE_FONT:  big_font = val[0];
                gbk_tl_pkg::CFG_GBK16_BASE:  base16   = val;
                gbk_tl_pkg::CFG_GB24_BASE:   base24   = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_draws.size();
        endfunction

        function void emit(gbk_tl_pkg::t_event ev, logic [7:0] code, logic [24:0] addr,
                           logic [6:0] nb);
            t_draw_cmd c;
            c.ev     = ev;
            c.x      = pen_x;
            c.y      = pen_y;
            c.code   = code;
            c.addr   = addr;
            c.nbytes = nb;
            expected_draws.push_back(c);
        endfunction

        // Wrap for an item w pixels wide; true when the pen line leaves the area
        function bit wrap_full(int w, int sz);
            int px, left, aw, py, top, ah;
            px   = pen_x;
            left = line_left;
            aw   = area_w;
            if (px > left + aw - w) begin
                pen_y = pen_y + 16'(sz);
                pen_x = line_left;
            end
            py  = pen_y;
            top = area_top;
            ah  = area_h;
            return py > top + ah - sz;
        endfunction

        // Advance the layout by one text byte; returns 0 if the byte is ignored
        function bit lay_out_byte(bit sos, logic [15:0] sx, logic [15:0] sy, logic [7:0] b);
            int          sz;
            int unsigned row, col, idx;
            logic [7:0]  r8, c8;
            sz = big_font ? 24 : 16;
            if (sos) begin
                pen_x        = sx;
                pen_y        = sy;
                line_left    = sx;
                area_top     = sy;
                lead_pending = 1'b0;
                halted       = 1'b0;
            end
            if (halted)
                return 1'b0;

            if (!lead_pending) begin
                if (b == gbk_tl_pkg::BYTE_END) begin
                    halted = 1'b1;
                    emit(gbk_tl_pkg::EV_STRING_END, 8'd0, 25'd0, 7'd0);
                end else if (b > gbk_tl_pkg::LEAD_THRESHOLD) begin
                    held_lead    = b;
                    lead_pending = 1'b1;
                end else if (wrap_full(sz / 2, sz)) begin
                    halted = 1'b1;
                    emit(gbk_tl_pkg::EV_AREA_FULL, 8'd0, 25'd0, 7'd0);
                end else if (b == gbk_tl_pkg::BYTE_CR) begin
                    pen_y = pen_y + 16'(sz);
                    pen_x = line_left;
                end else begin
                    emit(gbk_tl_pkg::EV_DRAW_CHAR, b, 25'd0, 7'd0);
                    pen_x = pen_x + 16'(sz / 2);
                end
                return 1'b1;
            end

            // trail byte of a two-byte code
            lead_pending = 1'b0;
            if (b == gbk_tl_pkg::BYTE_END) begin
                halted = 1'b1;
                emit(gbk_tl_pkg::EV_STRING_END, 8'd0, 25'd0, 7'd0);
                return 1'b1;
            end
            if (wrap_full(sz, sz)) begin
                halted = 1'b1;
                emit(gbk_tl_pkg::EV_AREA_FULL, 8'd0, 25'd0, 7'd0);
                return 1'b1;
            end
            if (!big_font) begin
                if (held_lead < gbk_tl_pkg::GBK_LEAD_MIN || b < gbk_tl_pkg::GBK_TRAIL_MIN ||
                    b == gbk_tl_pkg::GBK_INVALID || held_lead == gbk_tl_pkg::GBK_INVALID) begin
                    emit(gbk_tl_pkg::EV_BLANK_GLYPH, 8'd0, 25'd0, gbk_tl_pkg::BYTES_SMALL);
                end else begin
                    c8  = (b < gbk_tl_pkg::GBK_TRAIL_GAP) ? b - gbk_tl_pkg::GBK_TRAIL_MIN
                                                         : b - gbk_tl_pkg::GBK_TRAIL_SKIP;
                    r8  = held_lead - gbk_tl_pkg::GBK_LEAD_MIN;
                    col = c8;
                    row = r8;
                    idx = gbk_tl_pkg::GBK_ROW_LEN * row + col;
                    emit(gbk_tl_pkg::EV_DRAW_GLYPH, 8'd0, 25'(base16 + idx * 32),
                         gbk_tl_pkg::BYTES_SMALL);
                end
            end else begin
                // out of table codes wrap within 8 bits
                r8  = held_lead - gbk_tl_pkg::GB_OFFSET;
                c8  = b - gbk_tl_pkg::GB_OFFSET;
                row = r8;
                col = c8;
                idx = gbk_tl_pkg::GB_ROW_LEN * row + col;
                emit(gbk_tl_pkg::EV_DRAW_GLYPH, 8'd0, 25'(base24 + idx * 72),
                     gbk_tl_pkg::BYTES_LARGE);
            end
            pen_x = pen_x + 16'(sz);
            return 1'b1;
        endfunction

        function void mismatch(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        endfunction

        function void check_draw(t_draw_cmd got);
            t_draw_cmd want;
            if (expected_draws.size() == 0) begin
                errors++;
                $display("%0t: unexpected draw command, expected none, actual event %0d",
                         $time, got.ev);
                return;
            end
            want = expected_draws.pop_front();
            if (got.ev !== want.ev)         mismatch("event", want.ev, got.ev);
            if (got.x !== want.x)           mismatch("pos_x", want.x, got.x);
            if (got.y !== want.y)           mismatch("pos_y", want.y, got.y);
            if (got.code !== want.code)     mismatch("char_code", want.code, got.code);
            if (got.addr !== want.addr)     mismatch("glyph_addr", want.addr, got.addr);
            if (got.nbytes !== want.nbytes) mismatch("glyph_bytes", want.nbytes, got.nbytes);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [23:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // start_x[15:0], start_y[31:16], text_byte[39:32]
    logic [0:0]  s_axis_tuser;   // start_of_string[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;   // pos_x[15:0], pos_y[31:16], char_code[39:32],
                                 // glyph_addr[64:40], glyph_bytes[71:65]
    logic [2:0]  m_axis_tuser;   // event_res[2:0]

    draw_scoreboard sb;
    int tx_idle_pct;
    int rx_stall_pct;
    int max_len;
    int sent_in_phase;

    gbk_text_layout_glyph_address dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Output monitor; inputs only move at rising edges, so the falling edge is race free
    always @(negedge i_clk) begin
        t_draw_cmd got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.ev     = gbk_tl_pkg::t_event'(m_axis_tuser);
            got.x      = m_axis_tdata[15:0];
            got.y      = m_axis_tdata[31:16];
            got.code   = m_axis_tdata[39:32];
            got.addr   = m_axis_tdata[64:40];
            got.nbytes = m_axis_tdata[71:65];
            sb.check_draw(got);
        end
    end

    // Register write; valid stays high so back-to-back writes need no gap
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        bit acc;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(negedge i_clk);
            acc = o_cfg_ready;
            @(posedge i_clk);
        end while (!acc);
        sb.set_reg(idx, val);
    endtask

    task automatic write_config(input logic [15:0] w, input logic [15:0] h, input bit lf,
                                input logic [23:0] b16, input logic [23:0] b24);
        write_reg(gbk_tl_pkg::CFG_AREA_WIDTH, {8'd0, w});
        write_reg(gbk_tl_pkg::CFG_AREA_HEIGHT, {8'd0, h});
        write_reg(gbk_tl_pkg::CFG_LARGE_FONT, {23'd0, lf});
        write_reg(gbk_tl_pkg::CFG_GBK16_BASE, b16);
        write_reg(gbk_tl_pkg::CFG_GB24_BASE, b24);
        i_cfg_valid <= 1'b0;
    endtask

    // One text byte transaction, with optional idle cycles ahead of it
    task automatic send_byte(input bit sos, input logic [15:0] sx, input logic [15:0] sy,
                             input logic [7:0] b);
        bit acc;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, sy, sx};
        s_axis_tuser  <= sos;
        do begin
            @(negedge i_clk);
            acc = s_axis_tready;
            @(posedge i_clk);
        end while (!acc);
        void'(sb.lay_out_byte(sos, sx, sy, b));
        sent_in_phase++;
    endtask

    task automatic drain_draws();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_coord();
        int k;
        k = $urandom_range(9);
        if (k == 0)
            return 16'($urandom);
        if (k == 1)
            return 16'(16'hffff - $urandom_range(40));
        return 16'($urandom_range(64));
    endfunction

    function automatic logic [7:0] pick_lead();
        if (sb.big_font && $urandom_range(9) != 0)
            return 8'($urandom_range(8'ha1, 8'hfe));
        return 8'($urandom_range(8'h81, 8'hff));
    endfunction

    function automatic logic [7:0] pick_trail();
        int k;
        k = $urandom_range(19);
        case (k)
            0: return 8'($urandom_range(0, 8'h3f));
            1: return gbk_tl_pkg::GBK_INVALID;
            2: return gbk_tl_pkg::GBK_TRAIL_GAP;
            3: return gbk_tl_pkg::BYTE_END;
            4: return 8'($urandom_range(8'h80, 8'ha0));
            default: begin
                if (sb.big_font)
                    return 8'($urandom_range(8'ha1, 8'hfe));
                return 8'($urandom_range(8'h40, 8'hfe));
            end
        endcase
    endfunction

    // A string of random content; mostly well formed, some broken or followed by noise
    task automatic send_string();
        logic [7:0] text[$];
        int n, k;
        n = $urandom_range(max_len);
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 45) begin
                text.push_back(8'($urandom_range(1, 8'h80)));
            end else if (k < 55) begin
                text.push_back(gbk_tl_pkg::BYTE_CR);
            end else if (k < 90) begin
                text.push_back(pick_lead());
                text.push_back(pick_trail());
            end else if (k < 95) begin
                text.push_back(8'($urandom_range(8'h81, 8'hff)));
                text.push_back(8'($urandom));
            end else begin
                text.push_back(8'($urandom));
            end
        end
        k = $urandom_range(9);
        if (k < 7) begin
            text.push_back(gbk_tl_pkg::BYTE_END);
        end else if (k == 7) begin
            // dangling lead, cleared by the next string start
            text.push_back(8'($urandom_range(8'h81, 8'hff)));
        end else if (k == 9) begin
            text.push_back(gbk_tl_pkg::BYTE_END);
            repeat ($urandom_range(1, 3)) text.push_back(8'($urandom));
        end
        if (text.size() == 0)
            text.push_back(8'($urandom));
        foreach (text[i]) begin
            if (i == 0 || $urandom_range(99) < 2)
                send_byte(1'b1, pick_coord(), pick_coord(), text[i]);
            else
                send_byte(1'b0, 16'($urandom), 16'($urandom), text[i]);
        end
    endtask

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = gbk_tl_pkg::CFG_AREA_WIDTH;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        max_len       = 24;
        sent_in_phase = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset configuration, 16 pixel font
        send_byte(1'b0, 16'd1234, 16'd5678, 8'h41);       // stopped after reset
        send_byte(1'b1, 16'd0, 16'd0, 8'h41);
        send_byte(1'b0, 16'($urandom), 16'($urandom), gbk_tl_pkg::LEAD_THRESHOLD);
        send_byte(1'b0, 16'($urandom), 16'($urandom), gbk_tl_pkg::GBK_LEAD_MIN);
        send_byte(1'b0, 16'($urandom), 16'($urandom), gbk_tl_pkg::GBK_TRAIL_MIN);
        send_byte(1'b0, 16'($urandom), 16'($urandom), 8'hfe);
        send_byte(1'b0, 16'($urandom), 16'($urandom), 8'hfe);
        send_byte(1'b0, 16'($urandom), 16'($urandom), gbk_tl_pkg::GBK_LEAD_MIN);
        send_byte(1'b0, 16'($urandom), 16'($urandom), gbk_tl_pkg::GBK_TRAIL_GAP);
        send_byte(1'b0, 16'($urandom), 16'($urandom), 8'hc0);
        send_byte(1'b0, 16'($urandom), 16'($urandom), 8'h3f);   // trail too low
        send_byte(1'b0, 16'($urandom), 16'($urandom), gbk_tl_pkg::GBK_INVALID);
        send_byte(1'b0, 16'($urandom), 16'($urandom), 8'h80);
        send_byte(1'b0, 16'($urandom), 16'($urandom), 8'h90);
        send_byte(1'b0, 16'($urandom), 16'($urandom), gbk_tl_pkg::GBK_INVALID);
        send_byte(1'b0, 16'($urandom), 16'($urandom), gbk_tl_pkg::BYTE_CR);
        send_byte(1'b0, 16'($urandom), 16'($urandom), 8'h42);
        send_byte(1'b0, 16'($urandom), 16'($urandom), 8'h85);   // lead, then restart
        send_byte(1'b1, 16'hffff, 16'hffff, 8'h43);
        send_byte(1'b0, 16'($urandom), 16'($urandom), gbk_tl_pkg::BYTE_END);
        send_byte(1'b0, 16'($urandom), 16'($urandom), 8'h44);
        send_byte(1'b1, 16'd0, 16'd0, 8'hb0);
        send_byte(1'b0, 16'($urandom), 16'($urandom), gbk_tl_pkg::BYTE_END); // zero trail
        drain_draws();

        // Directed: small area, 24 pixel font, wrap into area full
        write_config(16'd40, 16'd40, 1'b1, 24'hffffff, 24'hffffff);
        send_byte(1'b1, 16'd0, 16'd0, 8'h61);
        send_byte(1'b0, 16'($urandom), 16'($urandom), gbk_tl_pkg::GB_OFFSET);
        send_byte(1'b0, 16'($urandom), 16'($urandom), gbk_tl_pkg::GB_OFFSET);
        send_byte(1'b0, 16'($urandom), 16'($urandom), gbk_tl_pkg::GBK_LEAD_MIN);
        send_byte(1'b0, 16'($urandom), 16'($urandom), 8'h20);
        send_byte(1'b0, 16'($urandom), 16'($urandom), 8'h7a);
        drain_draws();

        // Random phases over several area and font settings
        for (int p = 0; p < 8; p++) begin
            max_len = 24;
            case (p)
                0: write_config(16'd320, 16'd240, 1'b0, 24'd0, 24'd0);
                1: write_config(16'd200, 16'd100, 1'b1, 24'h123456, 24'hffffff);
                2: begin
                    write_config(16'd0, 16'd0, 1'b0, 24'hffffff, 24'd0);
                    max_len = 3;
                end
                3: write_config(16'hffff, 16'hffff, 1'b1, 24'd0, 24'habcdef);
                4: write_config(16'd96, 16'd64, 1'b0, 24'($urandom), 24'($urandom));
                5: write_config(16'd64, 16'd72, 1'b1, 24'($urandom), 24'($urandom));
                6: write_config(16'hffff, 16'hffff, 1'b0, 24'hffffff, 24'hffffff);
                default: write_config(16'($urandom_range(400)), 16'($urandom_range(300)),
                                      1'($urandom), 24'($urandom), 24'($urandom));
            endcase
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 73; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 73; end
                default: begin tx_idle_pct = 29; rx_stall_pct = 29; end
            endcase
            sent_in_phase = 0;
            while (sent_in_phase < 236)
                send_string();
            drain_draws();
        end

        if (sb.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
